// ===== hw/rtl/dcm3_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm3_pkg: shared types and constants
// Channel classes, configuration register indexes, saturation limits and
// the request/response bundles between the top level and the channel filters.
// ----------------------------------------------------------------------------
package dcm3_pkg;

  localparam int VAL_W   = 12;
  localparam int SUM_W   = 20;
  localparam int TALLY_W = 9;
  localparam int BAD_W   = 16;
  localparam int TAG_W   = 4;

  localparam int FRAME_MAX = 256;
  localparam int TALLY_LIM = (FRAME_MAX > 511) ? 511 : FRAME_MAX;

  localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(TALLY_LIM);
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [BAD_W-1:0]   BAD_MAX   = '1;

  localparam logic [TAG_W-1:0] FIRST_ID_RST  = 4'd0;
  localparam logic [TAG_W-1:0] SECOND_ID_RST = 4'd1;

  typedef enum logic [1:0] {
    CLS_FIRST  = 2'd0,
    CLS_SECOND = 2'd1,
    CLS_BAD    = 2'd2
  } cls_t;

  typedef enum logic {
    REG_FIRST_ID  = 1'b0,
    REG_SECOND_ID = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             push;
    logic             clear;
    logic [VAL_W-1:0] value;
  } chan_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W-1:0] count;
  } chan_res_t;

endpackage

// ===== hw/rtl/dcm3_in_if.sv =====
// ----------------------------------------------------------------------------
// dcm3_in_if: sample channel
// Valid/ready channel carrying one tagged converter sample per word.
// ----------------------------------------------------------------------------
interface dcm3_in_if;
  import dcm3_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] sample_channel;
  logic [VAL_W-1:0] sample_value;
  logic             frame_last;

  modport source (output valid, sample_channel, sample_value, frame_last, input ready);
  modport sink   (input valid, sample_channel, sample_value, frame_last, output ready);
endinterface

// ===== hw/rtl/dcm3_out_if.sv =====
// ----------------------------------------------------------------------------
// dcm3_out_if: result channel
// Valid/ready channel carrying one filtered result word with frame totals.
// ----------------------------------------------------------------------------
interface dcm3_out_if;
  import dcm3_pkg::*;

  logic               valid;
  logic               ready;
  cls_t               channel_class;
  logic [VAL_W-1:0]   filtered_value;
  logic [SUM_W-1:0]   first_sum;
  logic [TALLY_W-1:0] first_count;
  logic [SUM_W-1:0]   second_sum;
  logic [TALLY_W-1:0] second_count;
  logic [BAD_W-1:0]   bad_channel_total;
  logic               frame_done;

  modport source (output valid, channel_class, filtered_value, first_sum, first_count,
                  second_sum, second_count, bad_channel_total, frame_done,
                  input ready);
  modport sink   (input valid, channel_class, filtered_value, first_sum, first_count,
                  second_sum, second_count, bad_channel_total, frame_done,
                  output ready);
endinterface

// ===== hw/rtl/dual_channel_median3_frame_sum.sv =====
// A sample word passes the input register, then the result register, to the result port.
// Throughput: one word per cycle while out ready holds; the input register refills
// in the cycle the result register is loaded, so a steady stream never stalls.
// The rate is set by the single filter/accumulate pass between the two registers.
// Reset (rst_n low, synchronous) empties both registers, clears fill counts, frame
// sums, counts and the bad-channel total, and restores channel tags 0 and 1.
// ----------------------------------------------------------------------------
// dual_channel_median3_frame_sum: dual-channel median-of-three with frame sums
// Routes tagged samples to two median filters, sums and counts each channel per
// frame and keeps a saturating total of samples with an unknown tag.
// ----------------------------------------------------------------------------
module dual_channel_median3_frame_sum (
  input  logic                      clk,
  input  logic                      rst_n,
  dcm3_in_if.sink                   in_smp,
  dcm3_out_if.source                out_res,
  input  logic                      cfg_we,
  input  dcm3_pkg::reg_idx_t        cfg_idx,
  input  logic [dcm3_pkg::TAG_W-1:0] cfg_wdata
);
  import dcm3_pkg::*;

  // configuration
  logic [TAG_W-1:0] first_id_r, second_id_r;

  // input register
  logic             s_vld_r;
  logic [TAG_W-1:0] s_chan_r;
  logic [VAL_W-1:0] s_value_r;
  logic             s_last_r;

  // result register
  logic               o_vld_r;
  cls_t               o_cls_r, o_cls_nxt;
  logic [VAL_W-1:0]   o_fv_r, o_fv_nxt;
  logic [SUM_W-1:0]   o_fsum_r, o_ssum_r;
  logic [TALLY_W-1:0] o_fcnt_r, o_scnt_r;
  logic [BAD_W-1:0]   o_bad_r;
  logic               o_done_r;

  logic [BAD_W-1:0] bad_tally_r, bad_tally_nxt;

  logic      adv, in_take, sel_first, sel_second, is_bad;
  chan_req_t req_first, req_second;
  chan_res_t res_first, res_second;

  // Advance the held sample whenever the result register is free or being drained.
  assign adv          = s_vld_r && (!o_vld_r || out_res.ready);
  assign in_smp.ready = !s_vld_r || adv;
  assign in_take      = in_smp.valid && in_smp.ready;

  // Equal tags: the first channel wins.
  assign sel_first  = (s_chan_r == first_id_r);
  assign sel_second = !sel_first && (s_chan_r == second_id_r);
  assign is_bad     = !sel_first && !sel_second;

  always_comb begin
    req_first.push   = adv && sel_first;
    req_first.clear  = adv && s_last_r;
    req_first.value  = s_value_r;
    req_second.push  = adv && sel_second;
    req_second.clear = adv && s_last_r;
    req_second.value = s_value_r;

    priority if (sel_first) begin
      o_cls_nxt = CLS_FIRST;
      o_fv_nxt  = res_first.value;
    end else if (sel_second) begin
      o_cls_nxt = CLS_SECOND;
      o_fv_nxt  = res_second.value;
    end else begin
      o_cls_nxt = CLS_BAD;
      o_fv_nxt  = '0;
    end

    // saturating bad-tag total, counted as the sample leaves the input register
    bad_tally_nxt = bad_tally_r;
    if (adv && is_bad && (bad_tally_r != BAD_MAX)) bad_tally_nxt = bad_tally_r + 1'b1;
  end

  dcm3_chan u_first (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_first),
    .res   (res_first)
  );

  dcm3_chan u_second (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_second),
    .res   (res_second)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r  <= FIRST_ID_RST;
      second_id_r <= SECOND_ID_RST;
      s_vld_r     <= 1'b0;
      o_vld_r     <= 1'b0;
      bad_tally_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FIRST_ID:  first_id_r  <= cfg_wdata;
          REG_SECOND_ID: second_id_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_take) s_vld_r <= 1'b1;
      else if (adv) s_vld_r <= 1'b0;
      if (adv) o_vld_r <= 1'b1;
      else if (out_res.ready) o_vld_r <= 1'b0;
      bad_tally_r <= bad_tally_nxt;
    end
  end

  // payload: load the input register on accept, the result register on advance
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_chan_r  <= in_smp.sample_channel;
      s_value_r <= in_smp.sample_value;
      s_last_r  <= in_smp.frame_last;
    end
    if (adv) begin
      o_cls_r  <= o_cls_nxt;
      o_fv_r   <= o_fv_nxt;
      o_fsum_r <= res_first.sum;
      o_fcnt_r <= res_first.count;
      o_ssum_r <= res_second.sum;
      o_scnt_r <= res_second.count;
      o_bad_r  <= bad_tally_nxt;
      o_done_r <= s_last_r;
    end
  end

  assign out_res.valid             = o_vld_r;
  assign out_res.channel_class     = o_cls_r;
  assign out_res.filtered_value    = o_fv_r;
  assign out_res.first_sum         = o_fsum_r;
  assign out_res.first_count       = o_fcnt_r;
  assign out_res.second_sum        = o_ssum_r;
  assign out_res.second_count      = o_scnt_r;
  assign out_res.bad_channel_total = o_bad_r;
  assign out_res.frame_done        = o_done_r;

`ifndef SYNTHESIS
  // an unknown tag never yields a filtered value
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && (o_cls_r == CLS_BAD)) |-> (o_fv_r == '0))
    else $error("unknown-channel result carries a nonzero value");

  // the bad-tag total only grows
  a_bad_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (bad_tally_r >= $past(bad_tally_r)))
    else $error("bad-channel total decreased");

  // a first-channel result always counts its own sample
  a_first_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && (o_cls_r == CLS_FIRST)) |-> (o_fcnt_r != '0))
    else $error("first-channel result with zero count");

  // a second-channel result always counts its own sample
  a_second_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && (o_cls_r == CLS_SECOND)) |-> (o_scnt_r != '0))
    else $error("second-channel result with zero count");
`endif

endmodule

// ===== hw/rtl/dcm3_chan.sv =====
// ----------------------------------------------------------------------------
// dcm3_chan: one channel filter
// Three-entry ring with fill count, median-of-three, frame sum and count.
// ----------------------------------------------------------------------------
module dcm3_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  dcm3_pkg::chan_req_t req,
  output dcm3_pkg::chan_res_t res
);
  import dcm3_pkg::*;

  logic [VAL_W-1:0]   ring_r [3];
  logic [2:0]         fill_r, fill_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  logic [2:0]         fill_cur, fill_inc;
  logic [1:0]         slot;
  logic [VAL_W-1:0]   e0, e1, e2, lo, hi, med, fv;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_upd;
  logic [TALLY_W-1:0] tally_upd;

  always_comb begin
    fill_cur = (fill_r > 3'd5) ? 3'd0 : fill_r;
    unique case (fill_cur)
      3'd0, 3'd3: slot = 2'd0;
      3'd1, 3'd4: slot = 2'd1;
      3'd2, 3'd5: slot = 2'd2;
      default:    slot = 2'd0;
    endcase
    fill_inc = fill_cur + 3'd1;
    fill_nxt = (fill_inc == 3'd6) ? 3'd3 : fill_inc;

    // window with the new sample already in its slot
    e0 = (slot == 2'd0) ? req.value : ring_r[0];
    e1 = (slot == 2'd1) ? req.value : ring_r[1];
    e2 = (slot == 2'd2) ? req.value : ring_r[2];
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    priority if (e2 <= lo) med = lo;
    else if (e2 >= hi)     med = hi;
    else                   med = e2;

    // pass through until the ring is full
    fv = (fill_inc < 3'd3) ? req.value : med;

    sum_wide  = {1'b0, acc_r} + (SUM_W+1)'(fv);
    sum_upd   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    tally_upd = (tally_r < TALLY_CAP) ? tally_r + 1'b1 : tally_r;

    res.value = fv;
    res.sum   = req.push ? sum_upd : acc_r;
    res.count = req.push ? tally_upd : tally_r;

    priority if (req.clear) begin
      acc_nxt   = '0;
      tally_nxt = '0;
    end else begin
      acc_nxt   = res.sum;
      tally_nxt = res.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      acc_r   <= '0;
      tally_r <= '0;
    end else begin
      if (req.push) fill_r <= fill_nxt;
      acc_r   <= acc_nxt;
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) ring_r[slot] <= req.value;
  end

endmodule
